// File: rtl/cilb_pkg.sv
// shared types, widths and constants for the confidence interval lower bound block
package cilb_pkg;

    // fixed point format of the query and result fields
    localparam int FRAC_BITS = 16;
    localparam int CONF_W    = FRAC_BITS + 1;
    localparam int E_W       = $clog2(FRAC_BITS + 2);

    // internal quantile format and datapath widths
    localparam int QZ  = 24;
    localparam int Y_W = 28;
    localparam int HW  = 34;

    // ln(2) in Q.24 and the fixed tail quantile 99.0
    localparam logic [23:0] LN2_Q24 = 24'd11629080;
    localparam logic [31:0] Z_TAIL  = 32'd99 << QZ;

    // rational approximation coefficients in Q.24, highest power first
    localparam logic signed [HW-1:0] NUM_COEF [0:4] = '{
        -34'sd761, -34'sd342643, -34'sd5741869, -34'sd16777216, -34'sd5406163
    };
    localparam logic signed [HW-1:0] DEN_COEF [0:4] = '{
        34'sd64694, 34'sd1737075, 34'sd8910438, 34'sd9874760, 34'sd1666791
    };

    // one query beat
    typedef struct packed {
        logic [CONF_W-1:0] confidence;
        logic [31:0]       sample_count;
        logic signed [31:0] mean;
        logic [31:0]       std_dev;
    } query_t;

    // one result beat
    typedef struct packed {
        logic signed [31:0] lower_bound;
        logic               saturated;
    } result_t;

endpackage

// File: rtl/cilb_log_cell.sv
// one squaring step of the log2 fraction extraction
module cilb_log_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] m_in,
    input  logic [31:0] f_in,
    output logic [31:0] m_out,
    output logic [31:0] f_out
);

    logic [63:0] sq;
    logic [32:0] mm;
    logic [31:0] m_next;
    logic [31:0] f_next;

    // square the mantissa, renormalize and shift in one fraction bit
    always_comb
    begin
        sq = 64'(m_in) * 64'(m_in);
        mm = sq[63:31];
        if (mm[32])
        begin
            m_next = mm[32:1];
            f_next = {f_in[30:0], 1'b1};
        end
        else
        begin
            m_next = mm[31:0];
            f_next = {f_in[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_out <= m_next;
            f_out <= f_next;
        end
    end

endmodule

// File: rtl/cilb_sqrt_cell.sv
// one digit step of a restoring integer square root
module cilb_sqrt_cell #(
    parameter int RW = 64
) (
    input  logic               clk,
    input  logic               en,
    input  logic [RW/2+1:0]    rem_in,
    input  logic [RW/2-1:0]    root_in,
    input  logic [RW-1:0]      rad_in,
    output logic [RW/2+1:0]    rem_out,
    output logic [RW/2-1:0]    root_out,
    output logic [RW-1:0]      rad_out
);

    localparam int HWD = RW / 2;
    localparam int RMW = HWD + 2;

    logic [RMW+1:0] cand;
    logic [RMW+1:0] trial;
    logic [RMW+1:0] diff;
    logic           take;

    // bring down two radicand bits and try the next root bit
    always_comb
    begin
        cand  = {rem_in, rad_in[RW-1:RW-2]};
        trial = {2'b00, root_in, 2'b01};
        diff  = cand - trial;
        take  = (cand >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= take ? diff[RMW-1:0] : cand[RMW-1:0];
            root_out <= {root_in[HWD-2:0], take};
            rad_out  <= {rad_in[RW-3:0], 2'b00};
        end
    end

endmodule

// File: rtl/cilb_horner_cell.sv
// one horner step for numerator and denominator polynomials
module cilb_horner_cell #(
    parameter logic signed [cilb_pkg::HW-1:0] NUM_C = '0,
    parameter logic signed [cilb_pkg::HW-1:0] DEN_C = '0
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [cilb_pkg::Y_W-1:0]          y,
    input  logic signed [cilb_pkg::HW-1:0]    num_in,
    input  logic signed [cilb_pkg::HW-1:0]    den_in,
    output logic signed [cilb_pkg::HW-1:0]    num_out,
    output logic signed [cilb_pkg::HW-1:0]    den_out
);

    localparam int PW = cilb_pkg::HW + cilb_pkg::Y_W;

    logic [cilb_pkg::HW-1:0] num_mag;
    logic [cilb_pkg::HW-1:0] den_mag;
    logic [PW-1:0]           num_prod;
    logic [PW-1:0]           den_prod;
    logic [cilb_pkg::HW-1:0] num_sh;
    logic [cilb_pkg::HW-1:0] den_sh;
    logic signed [cilb_pkg::HW-1:0] num_mul;
    logic signed [cilb_pkg::HW-1:0] den_mul;

    // sign-magnitude multiply by y, truncated toward zero, then add coefficient
    always_comb
    begin
        num_mag  = num_in[cilb_pkg::HW-1] ? 34'(-num_in) : 34'(num_in);
        den_mag  = den_in[cilb_pkg::HW-1] ? 34'(-den_in) : 34'(den_in);
        num_prod = PW'(num_mag) * PW'(y);
        den_prod = PW'(den_mag) * PW'(y);
        num_sh   = num_prod[cilb_pkg::QZ+cilb_pkg::HW-1:cilb_pkg::QZ];
        den_sh   = den_prod[cilb_pkg::QZ+cilb_pkg::HW-1:cilb_pkg::QZ];
        num_mul  = num_in[cilb_pkg::HW-1] ? -$signed(num_sh) : $signed(num_sh);
        den_mul  = den_in[cilb_pkg::HW-1] ? -$signed(den_sh) : $signed(den_sh);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_out <= num_mul + NUM_C;
            den_out <= den_mul + DEN_C;
        end
    end

endmodule

// File: rtl/cilb_div_cell.sv
// one quotient bit of a restoring unsigned divider
module cilb_div_cell #(
    parameter int DW = 32,
    parameter int LW = 32
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [LW-1:0] low_in,
    input  logic [DW-1:0] div_in,
    output logic [DW-1:0] rem_out,
    output logic [LW-1:0] low_out,
    output logic [DW-1:0] div_out
);

    logic [DW:0] cand;
    logic [DW:0] diff;
    logic        take;

    // shift in the next dividend bit and subtract when it fits
    always_comb
    begin
        cand = {rem_in, low_in[LW-1]};
        diff = cand - {1'b0, div_in};
        take = (cand >= {1'b0, div_in});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out <= take ? diff[DW-1:0] : cand[DW-1:0];
            low_out <= {low_in[LW-2:0], take};
            div_out <= div_in;
        end
    end

endmodule

// File: rtl/confidence_interval_lower_bound.sv
// top level: normal confidence interval lower bound, mean - std_dev * z / sqrt(n)
//
// The block takes one query per clock while query_stall is low and returns one
// result per query, in order. The chain holds 32 squaring cells for the log2 of
// the tail, 28 root digit cells for y, 4 horner cells, 32 divider cells for the
// polynomial ratio and 48 divider cells for the final scaling by sqrt(n), which
// runs alongside the log cells in its own 32 root digit cells. The output register
// holds a result while result_stall is high; the chain keeps moving and taking
// queries until an item reaches its last cell, and only then does query_stall rise.
// Confidence at or above 1.0 gives z = 99, a sample count of zero counts as one,
// and a result below the Q16.16 range is clipped with saturated set.
module confidence_interval_lower_bound (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               query_valid,
    output logic               query_stall,
    input  cilb_pkg::query_t   query,
    output logic               result_valid,
    input  logic               result_stall,
    output cilb_pkg::result_t  result
);

    // cell counts and stage positions along the chain
    localparam int LOG_N  = 32;
    localparam int YS_N   = 28;
    localparam int NS_N   = 32;
    localparam int H_N    = 4;
    localparam int D1_N   = 32;
    localparam int D2_N   = 48;
    localparam int S_T1   = LOG_N + 1;
    localparam int S_T2   = S_T1 + 1;
    localparam int S_H0   = S_T2 + YS_N + 1;
    localparam int S_P    = S_H0 + H_N;
    localparam int S_Z    = S_P + D1_N + 1;
    localparam int S_M    = S_Z + 1;
    localparam int LAST   = S_M + D2_N;
    localparam int HW     = cilb_pkg::HW;
    localparam int Y_W    = cilb_pkg::Y_W;

    typedef struct packed {
        logic                     tail;
        logic [cilb_pkg::E_W-1:0] e;
        logic signed [31:0]       mean;
        logic [31:0]              sd;
        logic [31:0]              s;
        logic [Y_W-1:0]           y;
        logic                     neg;
    } side_t;

    logic            adv;
    logic [LAST:0]   v_reg;
    side_t           side_reg  [0:LAST];
    side_t           side_next [0:LAST];

    logic [31:0]     m0_reg;
    logic [31:0]     n0_reg;
    logic [5:0]      t_hi_reg;
    logic [31:0]     t_lo_reg;
    logic [31:0]     y2_reg;
    logic [31:0]     p_mag_reg;
    logic [31:0]     p_den_reg;
    logic [31:0]     z_reg;
    logic [63:0]     prod_reg;

    logic            result_valid_reg;
    cilb_pkg::result_t result_reg;

    // input stage decode
    logic [cilb_pkg::CONF_W-1:0] d;
    logic [cilb_pkg::E_W-1:0]    e_in;
    logic [31:0]                 m_in;

    // chain wiring
    logic [31:0]     lm [0:LOG_N];
    logic [31:0]     lf [0:LOG_N];
    logic [33:0]     rn_rem  [0:NS_N];
    logic [31:0]     rn_root [0:NS_N];
    logic [63:0]     rn_rad  [0:NS_N];
    logic [29:0]     ry_rem  [0:YS_N];
    logic [27:0]     ry_root [0:YS_N];
    logic [55:0]     ry_rad  [0:YS_N];
    logic signed [HW-1:0] hn [0:H_N];
    logic signed [HW-1:0] hd [0:H_N];
    logic [31:0]     d1_rem [0:D1_N];
    logic [31:0]     d1_low [0:D1_N];
    logic [31:0]     d1_div [0:D1_N];
    logic [31:0]     d2_rem [0:D2_N];
    logic [47:0]     d2_low [0:D2_N];
    logic [31:0]     d2_div [0:D2_N];

    // the chain moves unless a finished item would overwrite a waiting result
    assign adv         = !(result_valid_reg && result_stall && v_reg[LAST]);
    assign query_stall = !adv;

    // tail distance and leading one of the tail count
    always_comb
    begin
        d    = {1'b1, {cilb_pkg::FRAC_BITS{1'b0}}} - query.confidence;
        e_in = '0;
        for (int i = 0; i < cilb_pkg::CONF_W; i++)
        begin
            if (d[i])
            begin
                e_in = cilb_pkg::E_W'(i);
            end
        end
        m_in = 32'(d) << (5'd31 - 5'(e_in));
    end

    // sideband line, fields filled in as they become known
    always_comb
    begin
        side_next[0].tail = query.confidence[cilb_pkg::FRAC_BITS];
        side_next[0].e    = e_in;
        side_next[0].mean = query.mean;
        side_next[0].sd   = query.std_dev;
        side_next[0].s    = '0;
        side_next[0].y    = '0;
        side_next[0].neg  = 1'b0;
        for (int i = 1; i <= LAST; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
        side_next[S_T1].s   = rn_root[NS_N];
        side_next[S_H0].y   = ry_root[YS_N];
        side_next[S_P].neg  = hn[H_N][HW-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= LAST; i++)
            begin
                side_reg[i] <= side_next[i];
            end
        end
    end

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAST-1:0], query_valid};
        end
    end

    // input stage registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_reg <= m_in;
            n0_reg <= (query.sample_count == 32'd0) ? 32'd1 : query.sample_count;
        end
    end

    // log2 squaring cells
    assign lm[0] = m0_reg;
    assign lf[0] = '0;
    for (genvar k = 0; k < LOG_N; k++)
    begin : g_log
        cilb_log_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .m_in  (lm[k]),
            .f_in  (lf[k]),
            .m_out (lm[k+1]),
            .f_out (lf[k+1])
        );
    end

    // sqrt(n * 2^32) digit cells
    assign rn_rem[0]  = '0;
    assign rn_root[0] = '0;
    assign rn_rad[0]  = {n0_reg, 32'd0};
    for (genvar k = 0; k < NS_N; k++)
    begin : g_nsqrt
        cilb_sqrt_cell #(.RW(64)) u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (rn_rem[k]),
            .root_in  (rn_root[k]),
            .rad_in   (rn_rad[k]),
            .rem_out  (rn_rem[k+1]),
            .root_out (rn_root[k+1]),
            .rad_out  (rn_rad[k+1])
        );
    end

    // t = (F + 1 - e) - log2 fraction, then y2 = 2 ln2 t
    logic [5:0]  k_cnt;
    logic [37:0] t_full;
    logic [55:0] lo_prod;
    logic [29:0] hi_prod;
    logic [30:0] y2_sum;

    always_comb
    begin
        k_cnt   = 6'(cilb_pkg::FRAC_BITS + 1) - 6'(side_reg[LOG_N].e);
        t_full  = {k_cnt, 32'd0} - {6'd0, lf[LOG_N]};
        lo_prod = 56'(t_lo_reg) * 56'(cilb_pkg::LN2_Q24);
        hi_prod = 30'(t_hi_reg) * 30'(cilb_pkg::LN2_Q24);
        y2_sum  = 31'(hi_prod) + 31'(lo_prod[55:32]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_hi_reg <= t_full[37:32];
            t_lo_reg <= t_full[31:0];
            y2_reg   <= {y2_sum, 1'b0};
        end
    end

    // y = sqrt(y2 * 2^24) digit cells
    assign ry_rem[0]  = '0;
    assign ry_root[0] = '0;
    assign ry_rad[0]  = {y2_reg, 24'd0};
    for (genvar k = 0; k < YS_N; k++)
    begin : g_ysqrt
        cilb_sqrt_cell #(.RW(56)) u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (ry_rem[k]),
            .root_in  (ry_root[k]),
            .rad_in   (ry_rad[k]),
            .rem_out  (ry_rem[k+1]),
            .root_out (ry_root[k+1]),
            .rad_out  (ry_rad[k+1])
        );
    end

    // horner cells for numerator and denominator
    assign hn[0] = cilb_pkg::NUM_COEF[0];
    assign hd[0] = cilb_pkg::DEN_COEF[0];
    for (genvar k = 0; k < H_N; k++)
    begin : g_horner
        logic [Y_W-1:0] y_tap;
        if (k == 0)
        begin : g_first
            assign y_tap = ry_root[YS_N];
        end
        else
        begin : g_rest
            assign y_tap = side_reg[S_H0+k-1].y;
        end
        cilb_horner_cell #(
            .NUM_C (cilb_pkg::NUM_COEF[k+1]),
            .DEN_C (cilb_pkg::DEN_COEF[k+1])
        ) u_cell (
            .clk     (clk),
            .en      (adv),
            .y       (y_tap),
            .num_in  (hn[k]),
            .den_in  (hd[k]),
            .num_out (hn[k+1]),
            .den_out (hd[k+1])
        );
    end

    // ratio operands: numerator magnitude and a positive denominator
    logic [HW-1:0] num_abs;

    always_comb
    begin
        num_abs = hn[H_N][HW-1] ? HW'(-hn[H_N]) : HW'(hn[H_N]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_mag_reg <= num_abs[31:0];
            p_den_reg <= (hd[H_N] <= 0) ? 32'd1 : hd[H_N][31:0];
        end
    end

    // (|num| * 2^24) / den divider cells
    assign d1_rem[0] = {8'd0, p_mag_reg[31:8]};
    assign d1_low[0] = {p_mag_reg[7:0], 24'd0};
    assign d1_div[0] = p_den_reg;
    for (genvar k = 0; k < D1_N; k++)
    begin : g_div1
        cilb_div_cell #(.DW(32), .LW(32)) u_cell (
            .clk     (clk),
            .en      (adv),
            .rem_in  (d1_rem[k]),
            .low_in  (d1_low[k]),
            .div_in  (d1_div[k]),
            .rem_out (d1_rem[k+1]),
            .low_out (d1_low[k+1]),
            .div_out (d1_div[k+1])
        );
    end

    // z = |y + ratio|, or the tail value
    logic signed [33:0] ratio;
    logic signed [33:0] z_sum;
    logic [33:0]        z_abs;

    always_comb
    begin
        ratio = side_reg[S_Z-1].neg ? -$signed({2'b00, d1_low[D1_N]})
                                    : $signed({2'b00, d1_low[D1_N]});
        z_sum = $signed({6'd0, side_reg[S_Z-1].y}) + ratio;
        z_abs = z_sum[33] ? 34'(-z_sum) : 34'(z_sum);
    end

    // z register and std_dev * z product
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg    <= side_reg[S_Z-1].tail ? cilb_pkg::Z_TAIL : z_abs[31:0];
            prod_reg <= 64'(side_reg[S_Z].sd) * 64'(z_reg);
        end
    end

    // (std_dev * z) / sqrt(n) divider cells
    assign d2_rem[0] = {16'd0, prod_reg[63:48]};
    assign d2_low[0] = prod_reg[47:0];
    assign d2_div[0] = side_reg[S_M].s;
    for (genvar k = 0; k < D2_N; k++)
    begin : g_div2
        cilb_div_cell #(.DW(32), .LW(48)) u_cell (
            .clk     (clk),
            .en      (adv),
            .rem_in  (d2_rem[k]),
            .low_in  (d2_low[k]),
            .div_in  (d2_div[k]),
            .rem_out (d2_rem[k+1]),
            .low_out (d2_low[k+1]),
            .div_out (d2_div[k+1])
        );
    end

    // rounding, subtraction and clipping
    logic [49:0]        term_sum;
    logic [41:0]        term;
    logic signed [50:0] diff;
    cilb_pkg::result_t  result_next;

    always_comb
    begin
        term_sum = 50'(d2_low[D2_N]) + 50'd128;
        term     = term_sum[49:8];
        diff     = 51'(side_reg[LAST].mean) - $signed({9'd0, term});
        if (diff < -51'sd2147483648)
        begin
            result_next.lower_bound = 32'sh8000_0000;
            result_next.saturated   = 1'b1;
        end
        else if (diff > 51'sd2147483647)
        begin
            result_next.lower_bound = 32'sh7fff_ffff;
            result_next.saturated   = 1'b1;
        end
        else
        begin
            result_next.lower_bound = diff[31:0];
            result_next.saturated   = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (!result_valid_reg || !result_stall)
        begin
            result_valid_reg <= v_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || !result_stall)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        query_valid && !query_stall |=> v_reg[0])
        else $error("accepted query did not enter the chain");

    a_freeze_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall && v_reg[LAST] |-> query_stall)
        else $error("chain moved while a finished item had nowhere to go");

    a_root_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[S_T1] |-> side_reg[S_T1].s[31:16] != 16'd0)
        else $error("sqrt of sample count below one");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |-> result.lower_bound == 32'sh8000_0000)
        else $error("saturated result is not the range minimum");

    a_out_from_chain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(v_reg[LAST]))
        else $error("result appeared without a finished item");

endmodule
